// ===== hw/rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the crc-8 step for the sensor frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // frame geometry
    localparam int FRAME_LEN = 7;
    localparam int CRC_LEN   = 6;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // scaling: raw * scale >> 20
    localparam logic [13:0] HUM_SCALE  = 14'd10000;
    localparam logic [14:0] TEMP_SCALE = 15'd20000;
    localparam logic signed [15:0] TEMP_BIAS = 16'sd5000;

    // status bit positions
    localparam int BUSY_BIT  = 7;
    localparam int CALIB_BIT = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // configuration register indexes
    localparam logic CFG_HUM_OFFSET  = 1'b0;
    localparam logic CFG_TEMP_OFFSET = 1'b1;

    typedef logic [2:0] byte_pos_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_CRC  = 2'd1,
        ERR_ZERO = 2'd2
    } err_t;

    // one completed frame, handed from front to back
    typedef struct packed {
        logic [7:0]  status;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic [7:0]  crc;
        err_t        err;
    } frame_rec_t;

    // one byte through the crc-8 register
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes seven-byte humidity/temperature sensor replies into scaled readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one reply byte per request with
//   frame_start marking byte 0; a new start mark drops any partial frame.
//   Every seventh byte yields one result request on the output channel
//   (out_valid/out_stall) with raw fields, scaled readings, crc and error.
//   Config channel (cfg_valid/cfg_ready) writes the two signed offsets,
//   index 0 humidity, index 1 temperature; it is always ready.
// Throughput: one byte per cycle while in_stall is low, set by the crc-8
//   step in the front; the back retires one frame per cycle unless stalled.
// Path: the seventh byte's record is written to the queue, then registered
//   by the multiply stage and then by the offset stage, which drives out.
// Reset: clears the frame position, crc, queue and pipeline; offsets go to 0.
// Stall: a stalled result holds; the back fills behind it, then the
//   two-entry queue, and in_stall rises only when the queue is full.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [11:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          status_byte,
    output logic                busy_flag,
    output logic                calibrated_flag,
    output logic [19:0]         humidity_raw,
    output logic [19:0]         temperature_raw,
    output logic signed [14:0]  humidity_centi,
    output logic signed [15:0]  temperature_centi,
    output logic [7:0]          computed_crc,
    output logic [1:0]          error_code
);

    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;
    htfd_pkg::frame_rec_t push_rec;
    htfd_pkg::frame_rec_t pop_rec;

    logic [11:0]          hum_offset_reg;
    logic [11:0]          temp_offset_reg;

    // offset registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hum_offset_reg  <= '0;
            temp_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                htfd_pkg::CFG_HUM_OFFSET:  hum_offset_reg  <= cfg_data;
                htfd_pkg::CFG_TEMP_OFFSET: temp_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // byte intake and frame checks
    htfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (push_rec)
    );

    // frame record queue
    htfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_rec  (pop_rec)
    );

    // scaling and result output
    htfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .q_rec             (pop_rec),
        .hum_offset        (hum_offset_reg),
        .temp_offset       (temp_offset_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status_byte       (status_byte),
        .busy_flag         (busy_flag),
        .calibrated_flag   (calibrated_flag),
        .humidity_raw      (humidity_raw),
        .temperature_raw   (temperature_raw),
        .humidity_centi    (humidity_centi),
        .temperature_centi (temperature_centi),
        .computed_crc      (computed_crc),
        .error_code        (error_code)
    );

endmodule

// ===== hw/rtl/htfd_front.sv =====
// ----------------------------------------------------------------------------
// htfd_front
// Takes frame bytes, runs crc and zero tracking, builds a frame record.
// ----------------------------------------------------------------------------
module htfd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic                  frame_start,
    input  logic                  q_full,
    output logic                  q_push,
    output htfd_pkg::frame_rec_t  q_rec
);

    htfd_pkg::byte_pos_t pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    logic                zero_reg, zero_next;
    logic [7:0]          bytes_reg [htfd_pkg::CRC_LEN];

    htfd_pkg::byte_pos_t pos_eff;
    logic [7:0]          crc_eff;
    logic                zero_eff;
    logic                zero_new;
    logic                accept;
    logic                last_byte;

    // a start mark restarts the frame with this byte
    assign pos_eff  = frame_start ? '0 : pos_reg;
    assign crc_eff  = frame_start ? htfd_pkg::CRC_INIT : crc_reg;
    assign zero_eff = frame_start ? 1'b1 : zero_reg;
    assign zero_new = zero_eff & (rx_byte == 8'd0);

    assign in_stall  = q_full;
    assign accept    = in_valid & ~in_stall;
    assign last_byte = (pos_eff == htfd_pkg::byte_pos_t'(htfd_pkg::CRC_LEN));
    assign q_push    = accept & last_byte;

    // frame record from the stored bytes and the checksum byte
    always_comb
    begin
        q_rec.status   = bytes_reg[0];
        q_rec.hum_raw  = {bytes_reg[1], bytes_reg[2], bytes_reg[3][7:4]};
        q_rec.temp_raw = {bytes_reg[3][3:0], bytes_reg[4], bytes_reg[5]};
        q_rec.crc      = crc_eff;
        priority if (zero_new)
            q_rec.err = htfd_pkg::ERR_ZERO;
        else if (crc_eff != rx_byte)
            q_rec.err = htfd_pkg::ERR_CRC;
        else
            q_rec.err = htfd_pkg::ERR_OK;
    end

    // next frame tracking state
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        zero_next = zero_reg;
        if (accept) begin
            if (last_byte) begin
                pos_next  = '0;
                crc_next  = htfd_pkg::CRC_INIT;
                zero_next = 1'b1;
            end else begin
                pos_next  = pos_eff + 3'd1;
                crc_next  = htfd_pkg::crc8_step(crc_eff, rx_byte);
                zero_next = zero_new;
            end
        end
    end

    // tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            crc_reg  <= htfd_pkg::CRC_INIT;
            zero_reg <= 1'b1;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            zero_reg <= zero_next;
        end
    end

    // frame byte store
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < htfd_pkg::CRC_LEN; i++) begin
            if (accept && pos_eff == htfd_pkg::byte_pos_t'(i))
                bytes_reg[i] <= rx_byte;
        end
    end

endmodule

// ===== hw/rtl/htfd_queue.sv =====
// ----------------------------------------------------------------------------
// htfd_queue
// Short fifo of frame records between the front and the back.
// ----------------------------------------------------------------------------
module htfd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  htfd_pkg::frame_rec_t  push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output htfd_pkg::frame_rec_t  pop_rec
);

    htfd_pkg::frame_rec_t            mem_reg [htfd_pkg::QUEUE_DEPTH];
    logic [htfd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [htfd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [htfd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == htfd_pkg::QUEUE_CNT_W'(htfd_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == htfd_pkg::QUEUE_PTR_W'(htfd_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            if (rd_ptr_reg == htfd_pkg::QUEUE_PTR_W'(htfd_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// ===== hw/rtl/htfd_back.sv =====
// ----------------------------------------------------------------------------
// htfd_back
// Scales raw readings, adds offsets, subtracts the temperature bias and holds the result for the receiver.
// ----------------------------------------------------------------------------
module htfd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  htfd_pkg::frame_rec_t  q_rec,
    input  logic [11:0]           hum_offset,
    input  logic [11:0]           temp_offset,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            status_byte,
    output logic                  busy_flag,
    output logic                  calibrated_flag,
    output logic [19:0]           humidity_raw,
    output logic [19:0]           temperature_raw,
    output logic signed [14:0]    humidity_centi,
    output logic signed [15:0]    temperature_centi,
    output logic [7:0]            computed_crc,
    output logic [1:0]            error_code
);

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic                 s1_en;
    logic                 s2_en;

    htfd_pkg::frame_rec_t s1_rec_reg;
    logic [13:0]          s1_hum_reg;
    logic [14:0]          s1_temp_reg;

    logic [33:0]          hum_prod;
    logic [34:0]          temp_prod;
    logic signed [14:0]   hum_sum;
    logic signed [15:0]   temp_sum;

    htfd_pkg::frame_rec_t s2_rec_reg;
    logic signed [14:0]   s2_hum_reg;
    logic signed [15:0]   s2_temp_reg;

    // stage enables, the output stage frees when the receiver takes it
    assign s2_en = ~s2_valid_reg | ~out_stall;
    assign s1_en = ~s1_valid_reg | s2_en;
    assign q_pop = s1_en & ~q_empty;

    // stage one: constant multiplies
    assign hum_prod  = 34'(q_rec.hum_raw) * 34'(htfd_pkg::HUM_SCALE);
    assign temp_prod = 35'(q_rec.temp_raw) * 35'(htfd_pkg::TEMP_SCALE);

    // stage two: offsets and bias
    assign hum_sum  = signed'({1'b0, s1_hum_reg}) + signed'({{3{hum_offset[11]}}, hum_offset});
    assign temp_sum = signed'({1'b0, s1_temp_reg}) - htfd_pkg::TEMP_BIAS
                    + signed'({{4{temp_offset[11]}}, temp_offset});

    // valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_en)
            s1_valid_next = ~q_empty;
        if (s2_en)
            s2_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (s1_en) begin
            s1_rec_reg  <= q_rec;
            s1_hum_reg  <= hum_prod[33:20];
            s1_temp_reg <= temp_prod[34:20];
        end
        if (s2_en) begin
            s2_rec_reg  <= s1_rec_reg;
            s2_hum_reg  <= hum_sum;
            s2_temp_reg <= temp_sum;
        end
    end

    // result ports
    assign out_valid         = s2_valid_reg;
    assign status_byte       = s2_rec_reg.status;
    assign busy_flag         = s2_rec_reg.status[htfd_pkg::BUSY_BIT];
    assign calibrated_flag   = s2_rec_reg.status[htfd_pkg::CALIB_BIT];
    assign humidity_raw      = s2_rec_reg.hum_raw;
    assign temperature_raw   = s2_rec_reg.temp_raw;
    assign humidity_centi    = s2_hum_reg;
    assign temperature_centi = s2_temp_reg;
    assign computed_crc      = s2_rec_reg.crc;
    assign error_code        = s2_rec_reg.err;

endmodule
